// ===== rtl/rwlm_pkg.sv =====
// Shared types and codes of the reader-writer lock manager.
package rwlm_pkg;

	typedef enum logic [2:0] {
		OP_READ     = 3'd0,
		OP_TRY_READ = 3'd1,
		OP_WRITE    = 3'd2,
		OP_TRY_WRITE = 3'd3,
		OP_UNLOCK   = 3'd4
	} opcode_t;

	typedef enum logic [2:0] {
		STAT_GRANTED  = 3'd0,
		STAT_REFUSED  = 3'd1,
		STAT_QUEUED   = 3'd2,
		STAT_RELEASED = 3'd3,
		STAT_WOKEN    = 3'd4,
		STAT_ERROR    = 3'd5
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_WAKE
	} state_t;

	typedef struct packed {
		logic push;
		logic pop;
	} q_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// ===== rtl/rwlm_if.sv =====
// Request and result channel interfaces of the lock manager.
interface rwlm_req_if #(
	parameter int TID_W = 8
);
	logic             valid;
	logic             ready;
	logic [2:0]       opcode;
	logic [TID_W-1:0] thread_id;

	modport source (output valid, output opcode, output thread_id, input ready);
	modport sink (input valid, input opcode, input thread_id, output ready);
endinterface

interface rwlm_res_if #(
	parameter int TID_W = 8
);
	logic             valid;
	logic             ready;
	logic [TID_W-1:0] thread_id_res;
	logic [2:0]       status;
	logic             write_grant;
	logic             last;

	modport source (output valid, output thread_id_res, output status,
		output write_grant, output last, input ready);
	modport sink (input valid, input thread_id_res, input status,
		input write_grant, input last, output ready);
endinterface

// ===== rtl/rwlm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module rwlm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
endmodule

// ===== rtl/rwlm_queue.sv =====
// Circular FIFO of waiting thread ids held in a RAM, with head and fill count.
module rwlm_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  rwlm_pkg::q_cmd_t           cmd,
	input  logic [WIDTH-1:0]           wr_data,
	output rwlm_pkg::q_stat_t          stat,
	output logic [$clog2(DEPTH+1)-1:0] count,
	output logic [WIDTH-1:0]           rd_data
);
	import rwlm_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;

	logic [AW-1:0] head_q;
	logic [CW-1:0] cnt_q;
	logic [SW-1:0] tail_sum;
	logic [SW-1:0] tail_wrap;
	logic [AW-1:0] tail;

	assign tail_sum  = SW'(head_q) + SW'(cnt_q);
	assign tail_wrap = (tail_sum >= SW'(DEPTH)) ? tail_sum - SW'(DEPTH) : tail_sum;
	assign tail      = tail_wrap[AW-1:0];

	assign stat.full  = (cnt_q == CW'(DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign count      = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (cmd.pop) begin
				head_q <= (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
			end
			if (cmd.push && !cmd.pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (cmd.pop && !cmd.push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	rwlm_ram #(
		.WIDTH(WIDTH),
		.DEPTH(DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (cmd.push),
		.wr_addr(tail),
		.wr_data(wr_data),
		.rd_en  (cmd.pop),
		.rd_addr(head_q),
		.rd_data(rd_data)
	);
endmodule

// ===== rtl/reader_writer_lock_manager_top.sv =====
// Reader-preferring reader-writer lock manager for one lock.
// Each request word carries an opcode and a thread id; lock, try and write requests
// produce one result word each, and a new request is taken every cycle while the
// result side keeps up and no wake-up sequence runs, so only the output register
// and the wake-up sequence set the pace. An unlock that frees the lock returns its
// release word, then one woken word per waiter in queue order: each waiter is read
// from the waiting-thread RAM, whose read data is registered. Readers are granted
// whenever no writer holds the lock; blocking requests that cannot be granted wait
// in per-class FIFOs of QUEUE_DEPTH entries. Queue overflow, reader-count
// overflow, unlock of a free lock and unknown opcodes give an error word and leave
// the state unchanged. No clearing pass runs after reset.
module reader_writer_lock_manager_top #(
	parameter int QUEUE_DEPTH    = 16,
	parameter int MAX_READERS    = 255,
	parameter int THREAD_ID_BITS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	rwlm_req_if.sink   req,
	rwlm_res_if.source res
);
	import rwlm_pkg::*;

	localparam int CW  = $clog2(MAX_READERS + 1);
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);
	localparam int TW  = THREAD_ID_BITS;

	state_t         state_q, state_d;
	logic           writer_q, writer_d;
	logic [CW-1:0]  rcnt_q, rcnt_d;
	logic [QCW-1:0] left_q, left_d;
	logic           wake_wr_q, wake_wr_d;

	logic           res_valid_q;
	logic [TW-1:0]  res_tid_q;
	status_t        res_status_q;
	logic           res_wr_q;
	logic           res_last_q;

	logic           load;
	logic [TW-1:0]  ld_tid;
	status_t        ld_status;
	logic           ld_wr;
	logic           ld_last;

	logic           out_free;
	logic           accept;

	q_cmd_t         rq_cmd, wq_cmd;
	q_stat_t        rq_stat, wq_stat;
	logic [QCW-1:0] rq_count, wq_count;
	logic [TW-1:0]  rq_rdata, wq_rdata;
	logic [QCW-1:0] wake_n;
	logic [CW-1:0]  unl_cnt;

	assign out_free  = !res_valid_q || res.ready;
	assign req.ready = (state_q == S_IDLE) && out_free;
	assign accept    = req.valid && req.ready;

	assign wake_n  = (int'(rq_count) > MAX_READERS) ? QCW'(MAX_READERS) : rq_count;
	assign unl_cnt = writer_q ? '0 : rcnt_q - CW'(1);

	always_comb begin
		state_d   = state_q;
		writer_d  = writer_q;
		rcnt_d    = rcnt_q;
		left_d    = left_q;
		wake_wr_d = wake_wr_q;
		load      = 1'b0;
		ld_tid    = req.thread_id;
		ld_status = STAT_ERROR;
		ld_wr     = 1'b0;
		ld_last   = 1'b1;
		rq_cmd    = '0;
		wq_cmd    = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					load = 1'b1;
					case (opcode_t'(req.opcode))
						OP_READ, OP_TRY_READ: begin
							if (!writer_q) begin
								if (rcnt_q != CW'(MAX_READERS)) begin
									rcnt_d    = rcnt_q + CW'(1);
									ld_status = STAT_GRANTED;
								end
							end else if (req.opcode == OP_TRY_READ) begin
								ld_status = STAT_REFUSED;
							end else if (!rq_stat.full) begin
								rq_cmd.push = 1'b1;
								ld_status   = STAT_QUEUED;
							end
						end
						OP_WRITE, OP_TRY_WRITE: begin
							if (!writer_q && rcnt_q == '0) begin
								writer_d  = 1'b1;
								ld_status = STAT_GRANTED;
								ld_wr     = 1'b1;
							end else if (req.opcode == OP_TRY_WRITE) begin
								ld_status = STAT_REFUSED;
							end else if (!wq_stat.full) begin
								wq_cmd.push = 1'b1;
								ld_status   = STAT_QUEUED;
							end
						end
						OP_UNLOCK: begin
							if (writer_q || rcnt_q != '0) begin
								ld_status = STAT_RELEASED;
								writer_d  = 1'b0;
								rcnt_d    = unl_cnt;
								if (unl_cnt == '0 && !rq_stat.empty) begin
									rcnt_d     = CW'(wake_n);
									left_d     = wake_n;
									wake_wr_d  = 1'b0;
									rq_cmd.pop = 1'b1;
									ld_last    = 1'b0;
									state_d    = S_WAKE;
								end else if (unl_cnt == '0 && !wq_stat.empty) begin
									writer_d   = 1'b1;
									left_d     = QCW'(1);
									wake_wr_d  = 1'b1;
									wq_cmd.pop = 1'b1;
									ld_last    = 1'b0;
									state_d    = S_WAKE;
								end
							end
						end
						default: begin
							ld_status = STAT_ERROR;
						end
					endcase
				end
			end
			S_WAKE: begin
				if (out_free) begin
					load      = 1'b1;
					ld_tid    = wake_wr_q ? wq_rdata : rq_rdata;
					ld_status = STAT_WOKEN;
					ld_wr     = wake_wr_q;
					ld_last   = (left_q == QCW'(1));
					left_d    = left_q - QCW'(1);
					if (left_q == QCW'(1)) begin
						state_d = S_IDLE;
					end else begin
						rq_cmd.pop = !wake_wr_q;
						wq_cmd.pop = wake_wr_q;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			writer_q    <= 1'b0;
			rcnt_q      <= '0;
			left_q      <= '0;
			wake_wr_q   <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			writer_q  <= writer_d;
			rcnt_q    <= rcnt_d;
			left_q    <= left_d;
			wake_wr_q <= wake_wr_d;
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_tid_q    <= ld_tid;
			res_status_q <= ld_status;
			res_wr_q     <= ld_wr;
			res_last_q   <= ld_last;
		end
	end

	assign res.valid         = res_valid_q;
	assign res.thread_id_res = res_tid_q;
	assign res.status        = res_status_q;
	assign res.write_grant   = res_wr_q;
	assign res.last          = res_last_q;

	rwlm_queue #(
		.WIDTH(TW),
		.DEPTH(QUEUE_DEPTH)
	) u_rd_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (rq_cmd),
		.wr_data(req.thread_id),
		.stat   (rq_stat),
		.count  (rq_count),
		.rd_data(rq_rdata)
	);

	rwlm_queue #(
		.WIDTH(TW),
		.DEPTH(QUEUE_DEPTH)
	) u_wr_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (wq_cmd),
		.wr_data(req.thread_id),
		.stat   (wq_stat),
		.count  (wq_count),
		.rd_data(wq_rdata)
	);

	logic unused_wq_count;
	assign unused_wq_count = ^wq_count;
endmodule
